// ----- design/mcsp_pkg.sv -----
// Shared types and constants for the multi-channel servo pulse generator.
package mcsp_pkg;

    // Widths fixed by the item and register formats.
    localparam int OP_W      = 2;
    localparam int CHAN_W    = 5;
    localparam int VALUE_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int TICK_W    = 11;

    // Default sizing of the block.
    localparam int DEFAULT_CHANNELS   = 19;
    localparam int DEFAULT_IDLE_TICKS = 1020;

    // Ticks left in the idle gap after reset.
    localparam logic [TICK_W-1:0] RESET_IDLE_COUNT = TICK_W'(255);

    typedef logic signed [VALUE_W-1:0] setpoint_t;

    // Operation codes of an input item.
    typedef enum logic [OP_W-1:0] {
        OP_TICK    = 2'd0,
        OP_SET_ONE = 2'd1,
        OP_SET_ALL = 2'd2,
        OP_READ    = 2'd3
    } op_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_VALUE    = 2'd0,
        REG_MAX_VALUE    = 2'd1,
        REG_PULSE_OFFSET = 2'd2,
        REG_UNUSED       = 2'd3
    } cfg_reg_t;

    // Register reset values.
    localparam setpoint_t          MIN_VALUE_RESET    = -8'sd45;
    localparam setpoint_t          MAX_VALUE_RESET    = 8'sd45;
    localparam logic [VALUE_W-1:0] PULSE_OFFSET_RESET = 8'd90;

    // Decoded command of one accepted beat.
    typedef struct packed {
        logic tick;
        logic set_one;
        logic set_all;
        logic read;
    } cmd_t;

endpackage

// ----- design/mcsp_setpoint_bank.sv -----
// Pending setpoint storage with clamping, update-pending flag and read port.
module mcsp_setpoint_bank #(
    parameter int CHANNELS = mcsp_pkg::DEFAULT_CHANNELS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mcsp_pkg::cmd_t                  cmd,
    input  logic [mcsp_pkg::CHAN_W-1:0]     channel,
    input  mcsp_pkg::setpoint_t             value,
    input  mcsp_pkg::setpoint_t             min_value,
    input  mcsp_pkg::setpoint_t             max_value,
    input  logic                            commit,
    output mcsp_pkg::setpoint_t             pending [CHANNELS],
    output logic                            update_pending,
    output logic                            accepted,
    output mcsp_pkg::setpoint_t             read_value
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    mcsp_pkg::setpoint_t pending_reg [CHANNELS];
    mcsp_pkg::setpoint_t pending_next [CHANNELS];
    logic                update_pending_reg;
    logic                update_pending_next;
    mcsp_pkg::setpoint_t clamped;
    logic                in_range;
    logic [IDX_W-1:0]    idx;

    assign in_range = channel < mcsp_pkg::CHAN_W'(CHANNELS);
    assign idx      = channel[IDX_W-1:0];

    // With crossed limits, values above the upper limit take it, all others the lower.
    always_comb
    begin
        if (value > max_value)
        begin
            clamped = max_value;
        end
        else if (value < min_value)
        begin
            clamped = min_value;
        end
        else
        begin
            clamped = value;
        end
    end

    assign accepted = (cmd.set_one || cmd.set_all) && !update_pending_reg;

    always_comb
    begin
        pending_next        = pending_reg;
        update_pending_next = update_pending_reg;
        if (commit)
        begin
            update_pending_next = 1'b0;
        end
        if (accepted)
        begin
            update_pending_next = 1'b1;
            for (int i = 0; i < CHANNELS; i++)
            begin
                if (cmd.set_all || (in_range && (idx == IDX_W'(i))))
                begin
                    pending_next[i] = clamped;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                pending_reg[i] <= '0;
            end
            update_pending_reg <= 1'b0;
        end
        else
        begin
            pending_reg        <= pending_next;
            update_pending_reg <= update_pending_next;
        end
    end

    assign read_value     = (cmd.read && in_range) ? pending_reg[idx] : '0;
    assign pending        = pending_reg;
    assign update_pending = update_pending_reg;

endmodule

// ----- design/mcsp_frame_timer.sv -----
// Frame timing: idle countdown, high phase count, per-channel fall compares.
module mcsp_frame_timer #(
    parameter int CHANNELS   = mcsp_pkg::DEFAULT_CHANNELS,
    parameter int IDLE_TICKS = mcsp_pkg::DEFAULT_IDLE_TICKS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              tick,
    input  logic [mcsp_pkg::VALUE_W-1:0]      pulse_offset,
    input  mcsp_pkg::setpoint_t               pending [CHANNELS],
    input  logic                              update_pending,
    output logic [CHANNELS-1:0]               pins_next,
    output logic                              frame_start,
    output logic                              commit
);

    typedef enum logic {
        PH_IDLE,
        PH_HIGH
    } phase_t;

    localparam int TW = mcsp_pkg::TICK_W;

    phase_t                   phase_reg;
    phase_t                   phase_next;
    logic [TW-1:0]            tick_count_reg;
    logic [TW-1:0]            tick_count_next;
    logic [CHANNELS-1:0]      pins_reg;
    mcsp_pkg::setpoint_t      active_reg [CHANNELS];
    mcsp_pkg::setpoint_t      active_next [CHANNELS];
    logic [TW-1:0]            count_inc;
    logic [CHANNELS-1:0]      fall;
    logic [CHANNELS-1:0]      pins_after_fall;

    assign count_inc = tick_count_reg + TW'(1);

    // One end-time compare per channel, all in parallel.
    always_comb
    begin
        for (int i = 0; i < CHANNELS; i++)
        begin
            fall[i] = {{(TW - mcsp_pkg::VALUE_W){1'b0}},
                       mcsp_pkg::VALUE_W'(active_reg[i] + pulse_offset)} <= count_inc;
        end
    end

    assign pins_after_fall = pins_reg & ~fall;

    always_comb
    begin
        phase_next      = phase_reg;
        tick_count_next = tick_count_reg;
        pins_next       = pins_reg;
        active_next     = active_reg;
        frame_start     = 1'b0;
        commit          = 1'b0;
        if (tick)
        begin
            case (phase_reg)
                PH_HIGH:
                begin
                    tick_count_next = count_inc;
                    pins_next       = pins_after_fall;
                    if (pins_after_fall == '0)
                    begin
                        phase_next      = PH_IDLE;
                        tick_count_next = TW'(IDLE_TICKS);
                        if (update_pending)
                        begin
                            active_next = pending;
                            commit      = 1'b1;
                        end
                    end
                end
                default:
                begin
                    if (tick_count_reg <= TW'(1))
                    begin
                        phase_next      = PH_HIGH;
                        tick_count_next = '0;
                        pins_next       = '1;
                        frame_start     = 1'b1;
                    end
                    else
                    begin
                        tick_count_next = tick_count_reg - TW'(1);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            tick_count_reg <= mcsp_pkg::RESET_IDLE_COUNT;
            pins_reg       <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                active_reg[i] <= '0;
            end
        end
        else
        begin
            phase_reg      <= phase_next;
            tick_count_reg <= tick_count_next;
            pins_reg       <= pins_next;
            active_reg     <= active_next;
        end
    end

endmodule

// ----- design/mcsp_out_buffer.sv -----
// Result register with a skid stage between the block and the receiver.
module mcsp_out_buffer #(
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [DATA_W-1:0] out_data
);

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [DATA_W-1:0] out_data_reg;
    logic [DATA_W-1:0] out_data_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    logic [DATA_W-1:0] skid_data_reg;
    logic [DATA_W-1:0] skid_data_next;
    logic              out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = push;
                skid_data_next  = push_data;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- design/multi_channel_servo_pulse_generator.sv -----
// Top level of the multi-channel RC servo pulse generator.
//
// Usage: every input beat carries one operation. A tick advances frame
// time; set one and set all store a clamped setpoint in the pending bank
// (refused while an earlier update still waits); read returns the pending
// setpoint of a channel. Each input beat gives exactly one result beat with
// the pin levels after the operation, the accepted flag, the read value
// and a frame start flag.
// An accepted beat's result is registered in the result register, or in the
// skid stage while the receiver stalls. The block takes one beat per cycle
// while in_stall is low; all per-channel end-time compares run in parallel,
// so the single pass from state to result registers sets the rate.
// A skid stage behind the result register lets the block take one more beat
// while the receiver stalls; in_stall rises only when both stages hold a
// result, and then drops again once the receiver takes the output.
// Reset clears all setpoints to zero, restores the limit and offset
// registers to their defaults, drives all pins low and starts an idle gap
// of 255 ticks. Configuration writes take effect at the edge they occur.
module multi_channel_servo_pulse_generator #(
    parameter int CHANNELS   = mcsp_pkg::DEFAULT_CHANNELS,
    parameter int IDLE_TICKS = mcsp_pkg::DEFAULT_IDLE_TICKS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write port.
    input  logic                               cfg_write,
    input  logic [mcsp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mcsp_pkg::VALUE_W-1:0]       cfg_data,
    // Input channel.
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [mcsp_pkg::OP_W-1:0]          op,
    input  logic [mcsp_pkg::CHAN_W-1:0]        channel,
    input  logic signed [mcsp_pkg::VALUE_W-1:0] value,
    // Result channel.
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [CHANNELS-1:0]                pins,
    output logic                               accepted,
    output logic signed [mcsp_pkg::VALUE_W-1:0] read_value,
    output logic                               frame_start
);

    localparam int RES_W = CHANNELS + mcsp_pkg::VALUE_W + 2;

    mcsp_pkg::setpoint_t                min_value_reg;
    mcsp_pkg::setpoint_t                max_value_reg;
    logic [mcsp_pkg::VALUE_W-1:0]       pulse_offset_reg;

    logic                               beat_in;
    mcsp_pkg::cmd_t                     cmd;
    mcsp_pkg::setpoint_t                pending [CHANNELS];
    logic                               update_pending;
    logic                               set_accepted;
    mcsp_pkg::setpoint_t                rd_value;
    logic [CHANNELS-1:0]                pins_next;
    logic                               start;
    logic                               commit;
    logic                               buf_full;
    logic [RES_W-1:0]                   result;
    logic [RES_W-1:0]                   result_out;

    // Configuration registers; writes to the unused index are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_value_reg    <= mcsp_pkg::MIN_VALUE_RESET;
            max_value_reg    <= mcsp_pkg::MAX_VALUE_RESET;
            pulse_offset_reg <= mcsp_pkg::PULSE_OFFSET_RESET;
        end
        else if (cfg_write)
        begin
            case (mcsp_pkg::cfg_reg_t'(cfg_index))
                mcsp_pkg::REG_MIN_VALUE:    min_value_reg    <= cfg_data;
                mcsp_pkg::REG_MAX_VALUE:    max_value_reg    <= cfg_data;
                mcsp_pkg::REG_PULSE_OFFSET: pulse_offset_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    assign in_stall = buf_full;
    assign beat_in  = in_valid && !in_stall;

    // Decode the operation of an accepted beat.
    always_comb
    begin
        cmd = '0;
        if (beat_in)
        begin
            case (mcsp_pkg::op_t'(op))
                mcsp_pkg::OP_TICK:    cmd.tick    = 1'b1;
                mcsp_pkg::OP_SET_ONE: cmd.set_one = 1'b1;
                mcsp_pkg::OP_SET_ALL: cmd.set_all = 1'b1;
                mcsp_pkg::OP_READ:    cmd.read    = 1'b1;
                default:              cmd         = '0;
            endcase
        end
    end

    mcsp_setpoint_bank #(
        .CHANNELS (CHANNELS)
    ) u_bank (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .channel        (channel),
        .value          (value),
        .min_value      (min_value_reg),
        .max_value      (max_value_reg),
        .commit         (commit),
        .pending        (pending),
        .update_pending (update_pending),
        .accepted       (set_accepted),
        .read_value     (rd_value)
    );

    mcsp_frame_timer #(
        .CHANNELS   (CHANNELS),
        .IDLE_TICKS (IDLE_TICKS)
    ) u_timer (
        .clk            (clk),
        .rst_n          (rst_n),
        .tick           (cmd.tick),
        .pulse_offset   (pulse_offset_reg),
        .pending        (pending),
        .update_pending (update_pending),
        .pins_next      (pins_next),
        .frame_start    (start),
        .commit         (commit)
    );

    assign result = {pins_next, set_accepted, rd_value, start};

    mcsp_out_buffer #(
        .DATA_W (RES_W)
    ) u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (beat_in),
        .push_data (result),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (result_out)
    );

    assign pins        = result_out[RES_W-1 -: CHANNELS];
    assign accepted    = result_out[mcsp_pkg::VALUE_W + 1];
    assign read_value  = result_out[mcsp_pkg::VALUE_W:1];
    assign frame_start = result_out[0];

    // The skid stage only fills behind a held result.
    a_stall_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled while no result is held");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall))
        else $error("skid stage filled without a stalled result");

    // A frame start is a tick: every pin high, no set taken, nothing read.
    a_frame_start_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_start) |->
            (pins == {CHANNELS{1'b1}}) && !accepted && (read_value == '0))
        else $error("frame start result with wrong pins or flags");

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the multi-channel servo pulse generator.
module tb;

    // The block is built with its default sizing; the predictor uses the same.
    localparam int SERVO_CHANNELS = mcsp_pkg::DEFAULT_CHANNELS;
    localparam int IDLE_GAP_TICKS = mcsp_pkg::DEFAULT_IDLE_TICKS;

    // Cycles without any beat or register write before the run is declared hung.
    localparam int HANG_LIMIT = 2000;
    // Cycles to watch for stray results once everything has drained.
    localparam int SETTLE_CYCLES = 8;
    // Random part: one phase per register setting, the last one without idling.
    localparam int RANDOM_PHASES = 6;
    localparam int BEATS_PER_PHASE = 250;
    localparam int REPORT_LIMIT = 10;

    // One input beat as the driver presents it.
    typedef struct packed {
        mcsp_pkg::op_t                 op;
        logic [mcsp_pkg::CHAN_W-1:0]   channel;
        mcsp_pkg::setpoint_t           value;
    } servo_cmd_t;

    // One result beat, compared as a whole and reported field by field.
    typedef struct packed {
        logic [SERVO_CHANNELS-1:0] pins;
        logic                      accepted;
        mcsp_pkg::setpoint_t       read_value;
        logic                      frame_start;
    } servo_result_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_write = 1'b0;
    logic [mcsp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [mcsp_pkg::VALUE_W-1:0]   cfg_data = '0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic [mcsp_pkg::OP_W-1:0]      op = '0;
    logic [mcsp_pkg::CHAN_W-1:0]    channel = '0;
    mcsp_pkg::setpoint_t            value = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [SERVO_CHANNELS-1:0]      pins;
    logic                           accepted;
    mcsp_pkg::setpoint_t            read_value;
    logic                           frame_start;

    multi_channel_servo_pulse_generator #(
        .CHANNELS   (SERVO_CHANNELS),
        .IDLE_TICKS (IDLE_GAP_TICKS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .channel     (channel),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pins        (pins),
        .accepted    (accepted),
        .read_value  (read_value),
        .frame_start (frame_start)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Servo state as the testbench believes it to be. The pending bank takes
    // the writes, the active bank sets the fall times, and a single flag tells
    // whether a write is still waiting for the end of a high phase.
    // ------------------------------------------------------------------
    mcsp_pkg::setpoint_t            pending_sp [SERVO_CHANNELS];
    mcsp_pkg::setpoint_t            active_sp  [SERVO_CHANNELS];
    logic                           update_waiting;
    logic [mcsp_pkg::TICK_W-1:0]    frame_ticks;
    logic                           pulse_high;
    logic [SERVO_CHANNELS-1:0]      pin_levels;
    mcsp_pkg::setpoint_t            limit_min;
    mcsp_pkg::setpoint_t            limit_max;
    logic [mcsp_pkg::VALUE_W-1:0]   fall_offset;

    servo_cmd_t    cmd_q[$];
    servo_result_t predicted_results[$];

    int  fault_count = 0;
    int  quiet_cycles = 0;
    bit  beat_taken = 1'b0;
    bit  idling_on = 1'b1;
    int  send_gap = 0;
    int  stall_left = 0;

    // Applies one beat to the servo state and returns the result it should give.
    function automatic servo_result_t predict_servo(servo_cmd_t cmd);
        servo_result_t                res;
        mcsp_pkg::setpoint_t          clamped;
        logic [mcsp_pkg::VALUE_W-1:0] fall_at;
        res = '0;
        // With crossed limits, values above the upper limit take it, all others the lower.
        clamped = cmd.value;
        if (cmd.value > limit_max)
            clamped = limit_max;
        else if (cmd.value < limit_min)
            clamped = limit_min;
        case (cmd.op)
            mcsp_pkg::OP_TICK:
            begin
                if (!pulse_high)
                begin
                    // Idle gap: count down, and open a frame on the last tick.
                    if (frame_ticks <= 1)
                    begin
                        pin_levels = '1;
                        frame_ticks = '0;
                        pulse_high = 1'b1;
                        res.frame_start = 1'b1;
                    end
                    else
                        frame_ticks = frame_ticks - 1'b1;
                end
                else
                begin
                    // High phase: elapsed time first, then every channel whose
                    // fall time (setpoint plus offset, wrapped to 8 bits) is due.
                    frame_ticks = frame_ticks + 1'b1;
                    for (int i = 0; i < SERVO_CHANNELS; i++)
                    begin
                        fall_at = active_sp[i] + fall_offset;
                        if (fall_at <= frame_ticks)
                            pin_levels[i] = 1'b0;
                    end
                    if (pin_levels == '0)
                    begin
                        pulse_high = 1'b0;
                        frame_ticks = mcsp_pkg::TICK_W'(IDLE_GAP_TICKS);
                        if (update_waiting)
                        begin
                            active_sp = pending_sp;
                            update_waiting = 1'b0;
                        end
                    end
                end
            end
            mcsp_pkg::OP_SET_ONE:
            begin
                // An out-of-range channel stores nothing but still counts as taken.
                if (!update_waiting)
                begin
                    if (cmd.channel < SERVO_CHANNELS)
                        pending_sp[cmd.channel] = clamped;
                    update_waiting = 1'b1;
                    res.accepted = 1'b1;
                end
            end
            mcsp_pkg::OP_SET_ALL:
            begin
                if (!update_waiting)
                begin
                    for (int i = 0; i < SERVO_CHANNELS; i++)
                        pending_sp[i] = clamped;
                    update_waiting = 1'b1;
                    res.accepted = 1'b1;
                end
            end
            default:
            begin
                // Reads see the pending bank; out-of-range channels read zero.
                if (cmd.channel < SERVO_CHANNELS)
                    res.read_value = pending_sp[cmd.channel];
            end
        endcase
        res.pins = pin_levels;
        return res;
    endfunction

    task automatic flag_fault(string what, servo_result_t want, servo_result_t got);
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
        begin
            $display("[%0t] %s: expected pins=%h accepted=%b read=%0d frame=%b",
                     $realtime, what, want.pins, want.accepted, want.read_value,
                     want.frame_start);
            $display("    got pins=%h accepted=%b read=%0d frame=%b",
                     got.pins, got.accepted, got.read_value, got.frame_start);
        end
    endtask

    // ------------------------------------------------------------------
    // Input driver. A new beat is put up at the falling edge once the previous
    // one was taken at the rising edge before; a held beat never changes.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        servo_cmd_t next_cmd;
        if (rst_n && (!in_valid || beat_taken))
        begin
            if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap--;
            end
            else if (idling_on && $urandom_range(0, 7) == 0)
            begin
                in_valid <= 1'b0;
                send_gap = $urandom_range(1, 12) - 1;
            end
            else if (cmd_q.size() != 0)
            begin
                next_cmd = cmd_q.pop_front();
                in_valid <= 1'b1;
                op <= next_cmd.op;
                channel <= next_cmd.channel;
                value <= next_cmd.value;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result-side backpressure in bursts, independent of out_valid.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if (rst_n && idling_on && $urandom_range(0, 7) == 0)
        begin
            out_stall <= 1'b1;
            stall_left = $urandom_range(1, 12) - 1;
        end
        else
            out_stall <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Monitor. Everything is sampled at the rising edge, before the block's
    // own registers update: register writes and accepted input beats feed the
    // predictor, accepted result beats are checked against the oldest
    // prediction. A watchdog ends the run if nothing moves for too long.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        servo_cmd_t    taken_cmd;
        servo_result_t got;
        servo_result_t want;
        beat_taken = rst_n && in_valid && !in_stall;
        if (rst_n && cfg_write)
        begin
            case (mcsp_pkg::cfg_reg_t'(cfg_index))
                mcsp_pkg::REG_MIN_VALUE:    limit_min = cfg_data;
                mcsp_pkg::REG_MAX_VALUE:    limit_max = cfg_data;
                mcsp_pkg::REG_PULSE_OFFSET: fall_offset = cfg_data;
                default:                    ;
            endcase
        end
        if (beat_taken)
        begin
            taken_cmd.op = mcsp_pkg::op_t'(op);
            taken_cmd.channel = channel;
            taken_cmd.value = value;
            predicted_results.push_back(predict_servo(taken_cmd));
        end
        if (rst_n && out_valid && !out_stall)
        begin
            got.pins = pins;
            got.accepted = accepted;
            got.read_value = read_value;
            got.frame_start = frame_start;
            if (predicted_results.size() == 0)
                flag_fault("result beat with none expected", '0, got);
            else
            begin
                want = predicted_results.pop_front();
                if (got !== want)
                    flag_fault("result mismatch", want, got);
            end
        end
        if (!rst_n || beat_taken || (out_valid && !out_stall) || cfg_write)
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= HANG_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic add_cmd(mcsp_pkg::op_t kind, int unsigned chan,
                           logic [mcsp_pkg::VALUE_W-1:0] data);
        servo_cmd_t cmd;
        cmd.op = kind;
        cmd.channel = mcsp_pkg::CHAN_W'(chan);
        cmd.value = data;
        cmd_q.push_back(cmd);
    endtask

    // Waits until every queued beat went in and every predicted result came out.
    // Checked at the rising edge, where in_valid is stable and nothing new can
    // be predicted while it is low.
    task automatic wait_until_drained();
        do
            @(posedge clk);
        while (cmd_q.size() != 0 || in_valid || predicted_results.size() != 0);
    endtask

    task automatic write_reg(mcsp_pkg::cfg_reg_t idx, logic [mcsp_pkg::VALUE_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Stimulus. A directed opening at the reset settings, then random phases,
    // each after a register setting made while the block is idle.
    // ------------------------------------------------------------------
    initial
    begin
        servo_cmd_t  cmd;
        int unsigned pick;
        for (int i = 0; i < SERVO_CHANNELS; i++)
        begin
            pending_sp[i] = '0;
            active_sp[i] = '0;
        end
        update_waiting = 1'b0;
        frame_ticks = mcsp_pkg::RESET_IDLE_COUNT;
        pulse_high = 1'b0;
        pin_levels = '0;
        limit_min = mcsp_pkg::MIN_VALUE_RESET;
        limit_max = mcsp_pkg::MAX_VALUE_RESET;
        fall_offset = mcsp_pkg::PULSE_OFFSET_RESET;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // Reads of the first channel and beyond the bank, before anything was written.
        add_cmd(mcsp_pkg::OP_READ, 0, 8'h00);
        add_cmd(mcsp_pkg::OP_READ, 31, 8'hFF);
        // A set-one to a channel that does not exist still marks an update,
        // and the low extreme is clamped up to the lower limit.
        add_cmd(mcsp_pkg::OP_SET_ONE, 31, 8'h80);
        // With an update waiting, both kinds of set are refused.
        add_cmd(mcsp_pkg::OP_SET_ALL, 5, 8'h7F);
        add_cmd(mcsp_pkg::OP_SET_ONE, 0, 8'h7F);
        add_cmd(mcsp_pkg::OP_READ, 0, 8'h00);
        add_cmd(mcsp_pkg::OP_READ, SERVO_CHANNELS - 1, 8'h00);
        add_cmd(mcsp_pkg::OP_READ, SERVO_CHANNELS, 8'h00);
        // Ticks in the reset idle gap, with all other fields at their extremes.
        for (int i = 0; i < 14; i++)
            add_cmd(mcsp_pkg::OP_TICK, (i % 2) ? 31 : 0, (i % 2) ? 8'h7F : 8'h80);

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            wait_until_drained();
            case (ph)
                0:
                begin
                    // Widest limits, zero offset: fall times are the setpoints alone, wrapped to 8 bits.
                    write_reg(mcsp_pkg::REG_MIN_VALUE, 8'h80);
                    write_reg(mcsp_pkg::REG_MAX_VALUE, 8'h7F);
                    write_reg(mcsp_pkg::REG_PULSE_OFFSET, 8'd0);
                end
                1:
                begin
                    // Crossed limits: the upper limit decides for all but the lowest value; offset 254.
                    write_reg(mcsp_pkg::REG_MIN_VALUE, 8'h7F);
                    write_reg(mcsp_pkg::REG_MAX_VALUE, 8'h80);
                    write_reg(mcsp_pkg::REG_PULSE_OFFSET, 8'd254);
                end
                2:
                begin
                    write_reg(mcsp_pkg::REG_MIN_VALUE, -8'sd10);
                    write_reg(mcsp_pkg::REG_MAX_VALUE, 8'sd10);
                    write_reg(mcsp_pkg::REG_PULSE_OFFSET, 8'd200);
                end
                3:
                begin
                    write_reg(mcsp_pkg::REG_MIN_VALUE,
                              mcsp_pkg::VALUE_W'($urandom_range(0, 255)));
                    write_reg(mcsp_pkg::REG_MAX_VALUE,
                              mcsp_pkg::VALUE_W'($urandom_range(0, 255)));
                    write_reg(mcsp_pkg::REG_PULSE_OFFSET,
                              mcsp_pkg::VALUE_W'($urandom_range(0, 254)));
                end
                4:
                begin
                    write_reg(mcsp_pkg::REG_MIN_VALUE, 8'sd0);
                    write_reg(mcsp_pkg::REG_MAX_VALUE, 8'sd0);
                    write_reg(mcsp_pkg::REG_PULSE_OFFSET, 8'd128);
                end
                default:
                begin
                    write_reg(mcsp_pkg::REG_MIN_VALUE, mcsp_pkg::MIN_VALUE_RESET);
                    write_reg(mcsp_pkg::REG_MAX_VALUE, mcsp_pkg::MAX_VALUE_RESET);
                    write_reg(mcsp_pkg::REG_PULSE_OFFSET, mcsp_pkg::PULSE_OFFSET_RESET);
                end
            endcase
            // The closing phase runs at full rate on both sides.
            idling_on = (ph != RANDOM_PHASES - 1);
            // Mostly ticks, since frames and updates only move with time.
            for (int n = 0; n < BEATS_PER_PHASE; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 88)
                    cmd.op = mcsp_pkg::OP_TICK;
                else if (pick < 92)
                    cmd.op = mcsp_pkg::OP_SET_ONE;
                else if (pick < 96)
                    cmd.op = mcsp_pkg::OP_SET_ALL;
                else
                    cmd.op = mcsp_pkg::OP_READ;
                if ($urandom_range(0, 7) == 0)
                    cmd.channel = mcsp_pkg::CHAN_W'($urandom_range(SERVO_CHANNELS, 31));
                else
                    cmd.channel = mcsp_pkg::CHAN_W'($urandom_range(0, SERVO_CHANNELS - 1));
                if ($urandom_range(0, 5) == 0)
                    cmd.value = $urandom_range(0, 1) ? 8'h7F : 8'h80;
                else
                    cmd.value = mcsp_pkg::VALUE_W'($urandom_range(0, 255));
                cmd_q.push_back(cmd);
            end
        end

        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fault_count == 0 && predicted_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- sim.f -----
design/mcsp_pkg.sv
design/mcsp_setpoint_bank.sv
design/mcsp_frame_timer.sv
design/mcsp_out_buffer.sv
design/multi_channel_servo_pulse_generator.sv
tb/sv/tb.sv
